// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with active-low reset gating
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// clocked implication with reset gating
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

`endif

// ===== sv/jq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jq_pkg
// shared types and constants of the job queue
// ----------------------------------------------------------------------------
package jq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF    = 16;
    localparam int ID_BITS         = 16;
    localparam int OUT_TAG_BITS    = 16;
    localparam int IN_TDATA_BITS   = 40;
    localparam int OUT_TDATA_BITS  = 64;

    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;
    localparam logic [1:0] OP_REM = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FRONT_RD,
        S_FRONT_WAIT
    } t_state;

    typedef struct packed {
        logic [1:0]              status;
        logic [OUT_TAG_BITS-1:0] taken_job;
        logic [ID_BITS-1:0]      taken_requester;
        logic                    front_valid;
        logic [OUT_TAG_BITS-1:0] front_job;
        logic                    is_empty;
        logic [4:0]              entries_held;
    } t_result;

endpackage

// ===== sv/jq_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jq_mem
// entry store: one write port, one registered read port
// ----------------------------------------------------------------------------
module jq_mem #(
    parameter int DEPTH = 16,
    parameter int DW    = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/jq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jq_ctrl
// sequencer: circular queue pointers, scan and gap closing over the store
// ----------------------------------------------------------------------------
module jq_ctrl
    import jq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1),
    localparam int DW = ID_BITS + TAG_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic [15:0]        i_job_tag,
    input  logic [ID_BITS-1:0] i_requester_id,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_result            o_res,
    output logic               o_mem_we,
    output logic [AW-1:0]      o_mem_waddr,
    output logic [DW-1:0]      o_mem_wdata,
    output logic [AW-1:0]      o_mem_raddr,
    input  logic [DW-1:0]      i_mem_rdata
);

    t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head, r_tail, n_tail, r_p, n_p;
    logic [AW-1:0] r_j, n_j;
    logic [CW-1:0] r_count, n_count;
    logic [ID_BITS-1:0] r_rid, n_rid;
    logic [1:0] r_status, n_status;
    logic [DW-1:0] r_taken, n_taken;

    logic accept;
    logic [TAG_BITS-1:0] rd_job;
    logic [ID_BITS-1:0] rd_owner;
    logic more;
    logic more_shift;

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign rd_job     = i_mem_rdata[TAG_BITS-1:0];
    assign rd_owner   = i_mem_rdata[DW-1:TAG_BITS];
    assign more       = (CW'(r_j) + CW'(1)) < r_count;
    assign more_shift = (CW'(r_j) + CW'(2)) < r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
        r_p      <= n_p;
        r_j      <= n_j;
        r_rid    <= n_rid;
        r_status <= n_status;
        r_taken  <= n_taken;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_op)
                        OP_DEQ:  n_state = (r_count != '0) ? S_TAKE : S_FRONT_RD;
                        OP_REM:  n_state = (r_count != '0) ? S_SCAN_RD : S_FRONT_RD;
                        default: n_state = S_FRONT_RD;
                    endcase
                end
            end
            S_TAKE:     n_state = S_FRONT_RD;
            S_SCAN_RD:  n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (rd_owner == r_rid) begin
                    n_state = more ? S_SHIFT_RD : S_FRONT_RD;
                end else begin
                    n_state = more ? S_SCAN_RD : S_FRONT_RD;
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: n_state = more_shift ? S_SHIFT_RD : S_FRONT_RD;
            S_FRONT_RD: n_state = S_FRONT_WAIT;
            S_FRONT_WAIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_p         = r_p;
        n_j         = r_j;
        n_rid       = r_rid;
        n_status    = r_status;
        n_taken     = r_taken;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_tail;
        o_mem_wdata = {i_requester_id, TAG_BITS'(i_job_tag)};
        o_mem_raddr = r_head;
        o_in_ready  = (r_state == S_IDLE);
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rid    = i_requester_id;
                    n_status = ST_MISS;
                    n_taken  = '0;
                    n_p      = r_head;
                    n_j      = '0;
                    if (i_op == OP_ENQ) begin
                        if (r_count >= CW'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            o_mem_we = 1'b1;
                            n_tail   = inc_ptr(r_tail);
                            n_count  = r_count + 1'b1;
                            n_status = ST_DONE;
                        end
                    end
                end
            end
            S_TAKE: begin
                n_taken  = i_mem_rdata;
                n_status = ST_DONE;
                n_head   = inc_ptr(r_head);
                n_count  = r_count - 1'b1;
            end
            S_SCAN_RD: begin
                o_mem_raddr = r_p;
            end
            S_SCAN_CHK: begin
                if (rd_owner == r_rid) begin
                    n_taken  = i_mem_rdata;
                    n_status = ST_DONE;
                    if (!more) begin
                        n_tail  = r_p;
                        n_count = r_count - 1'b1;
                    end
                end else if (more) begin
                    n_p = inc_ptr(r_p);
                    n_j = r_j + 1'b1;
                end
            end
            S_SHIFT_RD: begin
                o_mem_raddr = inc_ptr(r_p);
            end
            S_SHIFT_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_p;
                o_mem_wdata = i_mem_rdata;
                n_p         = inc_ptr(r_p);
                n_j         = r_j + 1'b1;
                if (!more_shift) begin
                    n_tail  = inc_ptr(r_p);
                    n_count = r_count - 1'b1;
                end
            end
            S_FRONT_RD: begin
                o_mem_raddr = r_head;
            end
            S_FRONT_WAIT: begin
                o_res_valid           = 1'b1;
                o_res.status          = r_status;
                o_res.taken_job       = OUT_TAG_BITS'(r_taken[TAG_BITS-1:0]);
                o_res.taken_requester = r_taken[DW-1:TAG_BITS];
                o_res.front_valid     = (r_count != '0);
                o_res.front_job       = (r_count != '0) ? OUT_TAG_BITS'(rd_job) : '0;
                o_res.is_empty        = (r_count == '0);
                o_res.entries_held    = 5'(r_count);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/job_queue_with_remove_by_owner.sv =====
`timescale 1ns / 1ps
// remove reads and checks each entry scanned, then reads and writes each entry it shifts
// throughput: one item at a time; a new beat is taken only once the last result has been
// passed on, and the single read port of the entry store is walked one entry at a time
// reset: synchronous active low, clears pointers, count and handshake state
// entry store is not cleared; entries past the count are ignored wherever they are read
// ----------------------------------------------------------------------------
// job_queue_with_remove_by_owner
// bounded job queue with enqueue, dequeue and remove by requester
// ----------------------------------------------------------------------------
module job_queue_with_remove_by_owner
    import jq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // op[1:0], job_tag[17:2], requester_id[33:18], zero fill
    input  logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // status[1:0], taken_job[17:2], taken_requester[33:18], front_valid[34],
    // front_job[50:35], is_empty[51], entries_held[56:52], zero fill
    output logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int DW = ID_BITS + TAG_BITS;

    logic res_valid, res_ready;
    t_result res;
    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [DW-1:0] mem_wdata, mem_rdata;

    logic r_out_valid;
    t_result r_out;

    jq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_axis_tvalid),
        .o_in_ready     (o_s_axis_tready),
        .i_op           (i_s_axis_tdata[1:0]),
        .i_job_tag      (i_s_axis_tdata[17:2]),
        .i_requester_id (i_s_axis_tdata[33:18]),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    jq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.entries_held, r_out.is_empty, r_out.front_job,
                              r_out.front_valid, r_out.taken_requester, r_out.taken_job,
                              r_out.status};

endmodule

// ===== sv/jq_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jq_chk
// port-level checker for the job queue, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jq_chk
    import jq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      o_s_axis_tready,
    input logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata
);

    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
    `ASSERT_IMPL(a_empty_flags, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tdata[51] == !o_m_axis_tdata[34]) && (o_m_axis_tdata[51] == (o_m_axis_tdata[56:52] == 5'd0)))
    `ASSERT_IMPL(a_full_count, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tdata[1:0] == ST_FULL), o_m_axis_tdata[56:52] == 5'(QUEUE_DEPTH))

endmodule

bind job_queue_with_remove_by_owner jq_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_jq_chk (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the job queue with remove by requester
// beats of enqueue, dequeue, remove and the unused op code go in; a local copy of the queue predicts
// every result beat, which is compared field by field as it leaves the block
// ----------------------------------------------------------------------------
module tb;
    import jq_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [1:0] OP_NONE = 2'd3;

    class queue_scoreboard;
        logic [15:0] job_q[$];
        logic [15:0] owner_q[$];
        t_result     pending[$];
        int          errors;
        int          checked;

        function void note_request(logic [1:0] op, logic [15:0] tag, logic [15:0] rid);
            t_result r;
            int      hit;
            r = '0;
            r.status = ST_MISS;
            hit = -1;
            if (op == OP_ENQ) begin
                if (job_q.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    job_q.push_back(tag);
                    owner_q.push_back(rid);
                    r.status = ST_DONE;
                end
            end else if (op == OP_DEQ) begin
                if (job_q.size() > 0) hit = 0;
            end else if (op == OP_REM) begin
                for (int i = 0; i < owner_q.size(); i++) begin
                    if (hit < 0 && owner_q[i] == rid) hit = i;
                end
            end
            if (hit >= 0) begin
                r.status = ST_DONE;
                r.taken_job = job_q[hit];
                r.taken_requester = owner_q[hit];
                job_q.delete(hit);
                owner_q.delete(hit);
            end
            r.front_valid = job_q.size() > 0;
            r.front_job = job_q.size() > 0 ? job_q[0] : 16'd0;
            r.is_empty = job_q.size() == 0;
            r.entries_held = 5'(job_q.size());
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result e;
            checked++;
            if (pending.size() == 0) begin
                report("unexpected beat", got.taken_job, 16'd0);
                return;
            end
            e = pending.pop_front();
            if (got.status != e.status) report("status", got.status, e.status);
            if (got.taken_job != e.taken_job) report("taken_job", got.taken_job, e.taken_job);
            if (got.taken_requester != e.taken_requester)
                report("taken_requester", got.taken_requester, e.taken_requester);
            if (got.front_valid != e.front_valid)
                report("front_valid", got.front_valid, e.front_valid);
            if (got.front_job != e.front_job) report("front_job", got.front_job, e.front_job);
            if (got.is_empty != e.is_empty) report("is_empty", got.is_empty, e.is_empty);
            if (got.entries_held != e.entries_held)
                report("entries_held", got.entries_held, e.entries_held);
        endfunction

        function void report(string field, logic [15:0] got, logic [15:0] want);
            errors++;
            $display("mismatch on beat %0d: %s got %h want %h", checked, field, got, want);
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_axis_tvalid;
    logic                      o_s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata;

    queue_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  sent;
    int  n_enq, n_deq, n_rem, n_full;

    job_queue_with_remove_by_owner dut (.*);

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_result unpack_beat(logic [OUT_TDATA_BITS-1:0] d);
        t_result r;
        r.status          = d[1:0];
        r.taken_job       = d[17:2];
        r.taken_requester = d[33:18];
        r.front_valid     = d[34];
        r.front_job       = d[50:35];
        r.is_empty        = d[51];
        r.entries_held    = d[56:52];
        return r;
    endfunction

    // receiver side with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) sb.check_result(unpack_beat(o_m_axis_tdata));
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid stays up after an accept until the next beat or an idle cycle replaces it
    task automatic send_beat(logic [1:0] op, logic [15:0] tag, logic [15:0] rid);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, rid, tag, op};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_request(op, tag, rid);
        case (op)
            OP_ENQ: begin
                n_enq++;
                if (sb.pending[$].status == ST_FULL) n_full++;
            end
            OP_DEQ: n_deq++;
            OP_REM: n_rem++;
            default: ;
        endcase
        sent++;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // mostly a small pool of requesters so removes hit often
    task automatic random_beats(int count);
        logic [1:0]  op;
        logic [15:0] rid;
        int          k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(99);
            op = k < 45 ? OP_ENQ : (k < 70 ? OP_DEQ : (k < 97 ? OP_REM : OP_NONE));
            rid = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
            send_beat(op, 16'($urandom), rid);
        end
    endtask

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty cases, fill past full, removes at the head, in the middle and one that misses
        send_beat(OP_DEQ, 16'h0, 16'h0);
        send_beat(OP_REM, 16'h0, 16'hFFFF);
        send_beat(OP_NONE, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 17; i++)
            send_beat(OP_ENQ, i == 0 ? 16'hFFFF : 16'(i), i == 0 ? 16'hFFFF : 16'(i % 4));
        send_beat(OP_REM, 16'h0, 16'h3);
        send_beat(OP_REM, 16'h0, 16'hFFFF);
        send_beat(OP_REM, 16'h0, 16'h1234);
        send_beat(OP_DEQ, 16'h0, 16'h0);
        wait_drained();

        send_idle_pct = 9;
        recv_idle_pct = 80;
        random_beats(600);
        wait_drained();
        // drain queue to one entry and remove it by owner
        while (sb.job_q.size() > 1) send_beat(OP_DEQ, 16'h0, 16'h0);
        if (sb.job_q.size() == 1) send_beat(OP_REM, 16'h0, sb.owner_q[0]);
        wait_drained();
        send_idle_pct = 80;
        recv_idle_pct = 9;
        random_beats(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_beats(900);
        wait_drained();
        repeat (100) @(posedge i_clk);

        $display("covered %0d beats: %0d enqueue (%0d dropped full), %0d dequeue, %0d remove",
                 sent, n_enq, n_full, n_deq, n_rem);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+sv
sv/jq_pkg.sv
sv/jq_mem.sv
sv/jq_ctrl.sv
sv/job_queue_with_remove_by_owner.sv
sv/jq_chk.sv
tb/tb.sv
